[sv/iprt_pkg.sv]
package iprt_pkg;

  localparam int RULE_SLOTS = 64;
  localparam int IDX_W      = $clog2(RULE_SLOTS);
  localparam int CNT_W      = $clog2(RULE_SLOTS + 1);
  localparam int IP_W       = 32;
  localparam int PORT_W     = 16;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int OUT_CNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_CHECK = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ADDED    = 3'd0,
    STAT_INVALID  = 3'd1,
    STAT_DELETED  = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_ACCEPTED = 3'd4,
    STAT_REJECTED = 3'd5,
    STAT_FULL     = 3'd6
  } status_t;

  // how a request ends
  typedef enum logic [1:0] {
    FIN_INVALID,
    FIN_HIT,
    FIN_MISS
  } fin_kind_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [IP_W-1:0]   ip_lo;
    logic [IP_W-1:0]   ip_hi;
    logic [PORT_W-1:0] port_lo;
    logic [PORT_W-1:0] port_hi;
  } rule_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      scan;
    logic      finish;
    fin_kind_t kind;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
    logic hit;
    logic last;
  } dp_stat_t;

endpackage

[sv/iprt_ctrl.sv]
module iprt_ctrl import iprt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  dp_stat_t  stat,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.bad || stat.hit || stat.last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b0;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.finish = 1'b0;
    cmd.kind   = FIN_INVALID;
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_SCAN: begin
        busy     = 1'b1;
        cmd.scan = 1'b1;
        // malformed request ends before any slot is looked at
        if (stat.bad) begin
          cmd.finish = 1'b1;
          cmd.kind   = FIN_INVALID;
        end else if (stat.hit) begin
          cmd.finish = 1'b1;
          cmd.kind   = FIN_HIT;
        end else if (stat.last) begin
          cmd.finish = 1'b1;
          cmd.kind   = FIN_MISS;
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

[sv/iprt_dp.sv]
module iprt_dp import iprt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [IP_W-1:0]      in_ip_low,
  input  logic [IP_W-1:0]      in_ip_high,
  input  logic [PORT_W-1:0]    in_port_low,
  input  logic [PORT_W-1:0]    in_port_high,
  input  logic [IP_W-1:0]      in_probe_ip,
  input  logic [PORT_W-1:0]    in_probe_port,
  output dp_stat_t             stat,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [OUT_CNT_W-1:0] out_rule_count
);

  // captured request
  opcode_t           op_r;
  rule_t             req_r;
  logic [IP_W-1:0]   probe_ip_r;
  logic [PORT_W-1:0] probe_port_r;

  // rule store and scan pipeline
  rule_t                  mem [RULE_SLOTS];
  rule_t                  rd_data_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic                   rd_vld_r;
  logic [CNT_W-1:0]       idx_r;
  logic [RULE_SLOTS-1:0]  slot_valid_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [OUT_CNT_W-1:0]   out_count_r;
  status_t                status_nxt;

  logic slot_v;
  logic match_eq;
  logic match_cover;
  logic hit_raw;
  logic bounds_bad;
  logic add_hit;
  logic del_hit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r          <= opcode_t'(in_opcode);
      req_r.ip_lo   <= in_ip_low;
      req_r.ip_hi   <= in_ip_high;
      req_r.port_lo <= in_port_low;
      req_r.port_hi <= in_port_high;
      probe_ip_r    <= in_probe_ip;
      probe_port_r  <= in_probe_port;
    end
  end

  assign bounds_bad = (req_r.ip_lo > req_r.ip_hi) || (req_r.port_lo > req_r.port_hi);

  assign stat.bad = (op_r == OP_CHECK) ? 1'b0 :
                    (op_r == OP_RSVD)  ? 1'b1 : bounds_bad;

  // compare stage on the registered read
  assign slot_v      = slot_valid_r[rd_idx_r];
  assign match_eq    = (rd_data_r == req_r);
  assign match_cover = (probe_ip_r >= rd_data_r.ip_lo) && (probe_ip_r <= rd_data_r.ip_hi) &&
                       (probe_port_r >= rd_data_r.port_lo) &&
                       (probe_port_r <= rd_data_r.port_hi);

  always_comb begin
    case (op_r)
      OP_ADD:   hit_raw = !slot_v;
      OP_DEL:   hit_raw = slot_v && match_eq;
      OP_CHECK: hit_raw = slot_v && match_cover;
      default:  hit_raw = 1'b0;
    endcase
  end

  assign stat.hit  = rd_vld_r && hit_raw;
  assign stat.last = rd_vld_r && (rd_idx_r == IDX_W'(RULE_SLOTS - 1));

  assign add_hit = cmd.finish && (cmd.kind == FIN_HIT) && (op_r == OP_ADD);
  assign del_hit = cmd.finish && (cmd.kind == FIN_HIT) && (op_r == OP_DEL);

  // memory: one read a cycle during the scan, one write on a successful add
  always_ff @(posedge clk) begin
    if (add_hit) begin
      mem[rd_idx_r] <= req_r;
    end
    rd_data_r <= mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      idx_r    <= '0;
      rd_idx_r <= '0;
    end else if (cmd.load || cmd.finish) begin
      rd_vld_r <= 1'b0;
      idx_r    <= '0;
    end else if (cmd.scan) begin
      if (idx_r < CNT_W'(RULE_SLOTS)) begin
        rd_vld_r <= 1'b1;
        rd_idx_r <= idx_r[IDX_W-1:0];
        idx_r    <= idx_r + 1'b1;
      end else begin
        rd_vld_r <= 1'b0;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (add_hit) begin
      count_nxt = count_r + 1'b1;
    end else if (del_hit) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      count_r      <= '0;
    end else begin
      count_r <= count_nxt;
      if (add_hit) begin
        slot_valid_r[rd_idx_r] <= 1'b1;
      end else if (del_hit) begin
        slot_valid_r[rd_idx_r] <= 1'b0;
      end
    end
  end

  always_comb begin
    status_nxt = STAT_INVALID;
    case (cmd.kind)
      FIN_HIT: begin
        case (op_r)
          OP_ADD:   status_nxt = STAT_ADDED;
          OP_DEL:   status_nxt = STAT_DELETED;
          OP_CHECK: status_nxt = STAT_ACCEPTED;
          default:  status_nxt = STAT_INVALID;
        endcase
      end
      FIN_MISS: begin
        case (op_r)
          OP_ADD:   status_nxt = STAT_FULL;
          OP_DEL:   status_nxt = STAT_NOTFOUND;
          OP_CHECK: status_nxt = STAT_REJECTED;
          default:  status_nxt = STAT_INVALID;
        endcase
      end
      default: status_nxt = STAT_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= status_nxt;
      out_count_r  <= OUT_CNT_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_rule_count = out_count_r;

endmodule

[sv/ip_port_range_rule_table.sv]
// firewall rule table of RULE_SLOTS rules, each an inclusive ipv4 range and
// an inclusive port range. a request (add, delete or check) is taken on a
// clock edge with start high and busy low; busy then stays high during a
// scan of the rule memory one slot per cycle through its single read port,
// stopping at the first free slot (add), first equal rule (delete) or first
// covering rule (check), or at the last slot. malformed requests and the
// unused opcode finish before any slot is looked at.
// the answer (status and rule count after the request) is shown with
// out_valid for exactly one cycle, the first cycle in which busy is low;
// there is no back-pressure, so the receiver must take it then. a new
// request may be started in that same cycle. rule valid marks and the rule
// count are cleared by reset, so no clearing pass is needed.
module ip_port_range_rule_table import iprt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [IP_W-1:0]      in_ip_low,
  input  logic [IP_W-1:0]      in_ip_high,
  input  logic [PORT_W-1:0]    in_port_low,
  input  logic [PORT_W-1:0]    in_port_high,
  input  logic [IP_W-1:0]      in_probe_ip,
  input  logic [PORT_W-1:0]    in_probe_port,
  // result channel, one-cycle strobe
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [OUT_CNT_W-1:0] out_rule_count
);

  // command and status between controller and datapath
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: idle, then scan until bad request, hit or last slot
  iprt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // rule memory, valid marks, rule count, compare and result registers
  iprt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_opcode      (in_opcode),
    .in_ip_low      (in_ip_low),
    .in_ip_high     (in_ip_high),
    .in_port_low    (in_port_low),
    .in_port_high   (in_port_high),
    .in_probe_ip    (in_probe_ip),
    .in_probe_port  (in_probe_port),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_rule_count (out_rule_count)
  );

endmodule
